// ===== src/aria_pkg.sv =====
package aria_pkg;

  localparam int unsigned BlkW = 128;
  localparam int unsigned CfgW = 64;
  localparam int unsigned IdxW = 3;
  localparam int unsigned MaxKeys = 17;
  localparam int unsigned FifoDepthDef = 2;

  typedef enum logic [IdxW-1:0] {
    RegKey0 = 3'd0,
    RegKey1 = 3'd1,
    RegKey2 = 3'd2,
    RegKey3 = 3'd3,
    RegKeyLen = 3'd4,
    RegDir = 3'd5
  } reg_idx_e;

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] r;
    x = a;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [7:0] gpow(input logic [7:0] a, input int unsigned e);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h01;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (e[i]) r = gmul(r, p);
      p = gmul(p, p);
    end
    return r;
  endfunction

  function automatic logic [7:0] s1_f(input logic [7:0] x);
    logic [7:0] b;
    logic [7:0] s;
    b = (x == 8'h00) ? 8'h00 : gpow(x, 254);
    s = b;
    for (int k = 1; k <= 4; k++) s = s ^ ((b << k) | (b >> (8 - k)));
    return s ^ 8'h63;
  endfunction

  function automatic logic [7:0] s2_f(input logic [7:0] x);
    logic [7:0] rows [8];
    logic [7:0] p;
    logic [7:0] t;
    rows = '{8'h7A, 8'hBC, 8'hEB, 8'hB9, 8'h34, 8'h81, 8'hBA, 8'hCB};
    p = (x == 8'h00) ? 8'h00 : gpow(x, 247);
    for (int i = 0; i < 8; i++) t[i] = ^(rows[i] & p);
    return t ^ 8'hE2;
  endfunction

  typedef logic [7:0] sbox_t [256];

  function automatic sbox_t mk_s1();
    sbox_t t;
    for (int i = 0; i < 256; i++) t[i] = s1_f(8'(i));
    return t;
  endfunction

  function automatic sbox_t mk_s2();
    sbox_t t;
    for (int i = 0; i < 256; i++) t[i] = s2_f(8'(i));
    return t;
  endfunction

  function automatic sbox_t mk_x1();
    sbox_t t;
    for (int i = 0; i < 256; i++) t[s1_f(8'(i))] = 8'(i);
    return t;
  endfunction

  function automatic sbox_t mk_x2();
    sbox_t t;
    for (int i = 0; i < 256; i++) t[s2_f(8'(i))] = 8'(i);
    return t;
  endfunction

  localparam sbox_t S1 = mk_s1();
  localparam sbox_t S2 = mk_s2();
  localparam sbox_t X1 = mk_x1();
  localparam sbox_t X2 = mk_x2();

  localparam logic [BlkW-1:0] CK0 = 128'h517cc1b727220a94fe13abe8fa9a6ee0;
  localparam logic [BlkW-1:0] CK1 = 128'h6db14acc9e21c820ff28b1d5ef5de2b0;
  localparam logic [BlkW-1:0] CK2 = 128'hdb92371d2126e9700324977504e8c90e;

  function automatic logic [7:0] byte_of(input logic [BlkW-1:0] v, input int unsigned i);
    return v[BlkW-1-8*i -: 8];
  endfunction

  // odd: S1,S2,X1,X2 ; even: X1,X2,S1,S2
  function automatic logic [BlkW-1:0] subst(input logic [BlkW-1:0] v, input logic even);
    logic [BlkW-1:0] o;
    logic [7:0] b;
    for (int i = 0; i < 16; i++) begin
      b = byte_of(v, i);
      case ((i + (even ? 2 : 0)) % 4)
        0: o[BlkW-1-8*i -: 8] = S1[b];
        1: o[BlkW-1-8*i -: 8] = S2[b];
        2: o[BlkW-1-8*i -: 8] = X1[b];
        default: o[BlkW-1-8*i -: 8] = X2[b];
      endcase
    end
    return o;
  endfunction

  function automatic logic [BlkW-1:0] diffuse(input logic [BlkW-1:0] v);
    int unsigned taps [16][7];
    logic [BlkW-1:0] o;
    logic [7:0] a;
    taps = '{'{3,4,6,8,9,13,14}, '{2,5,7,8,9,12,15}, '{1,4,6,10,11,12,15},
             '{0,5,7,10,11,13,14}, '{0,2,5,8,11,14,15}, '{1,3,4,9,10,14,15},
             '{0,2,7,9,10,12,13}, '{1,3,6,8,11,12,13}, '{0,1,4,7,10,13,15},
             '{0,1,5,6,11,12,14}, '{2,3,5,6,8,13,15}, '{2,3,4,7,9,12,14},
             '{1,2,6,7,9,11,12}, '{0,3,6,7,8,10,13}, '{0,3,4,5,9,11,14},
             '{1,2,4,5,8,10,15}};
    for (int i = 0; i < 16; i++) begin
      a = 8'h00;
      for (int j = 0; j < 7; j++) a = a ^ byte_of(v, taps[i][j]);
      o[BlkW-1-8*i -: 8] = a;
    end
    return o;
  endfunction

  function automatic logic [BlkW-1:0] rotr(input logic [BlkW-1:0] v, input logic [2:0] sel);
    case (sel)
      3'd0: return {v[18:0], v[BlkW-1:19]};
      3'd1: return {v[30:0], v[BlkW-1:31]};
      3'd2: return {v[66:0], v[BlkW-1:67]};
      3'd3: return {v[96:0], v[BlkW-1:97]};
      default: return {v[108:0], v[BlkW-1:109]};
    endcase
  endfunction

endpackage

// ===== src/aria_block_cipher.sv =====
// aria block cipher, ecb, iterative round loop
// rounds = 12, 14 or 16, set by the key length
// a new block starts only after the last result is taken; the input fifo buffers blocks
// the first item after a key, length or direction write waits for the key schedule
// reset (async, active low) clears control and key regs; round keys rebuilt on demand
module aria_block_cipher import aria_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [IdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            valid_i,
  output logic            stall_o,
  input  logic [63:0]     block_high_i,
  input  logic [63:0]     block_low_i,
  output logic            valid_o,
  input  logic            stall_i,
  output logic [63:0]     result_high_o,
  output logic [63:0]     result_low_o
);
  logic q_valid, q_pop;
  logic [BlkW-1:0] q_data, res;

  aria_front #(.Depth(FifoDepth)) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .data_i({block_high_i, block_low_i}),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  aria_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .valid_o, .stall_i, .data_o(res)
  );

  assign result_high_o = res[127:64];
  assign result_low_o  = res[63:0];
endmodule

// ===== src/aria_ram.sv =====
module aria_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 34
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/aria_front.sv =====
module aria_front import aria_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  logic [BlkW-1:0] data_i,
  output logic            q_valid_o,
  input  logic            q_pop_i,
  output logic [BlkW-1:0] q_data_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  logic [BlkW-1:0] buf_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic push;

  assign stall_o   = (cnt_q == (PtrW+1)'(Depth));
  assign push      = valid_i && !stall_o;
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o  = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == PtrW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (q_pop_i) rp_q <= (rp_q == PtrW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
    end
  end
endmodule

// ===== src/aria_back.sv =====
module aria_back import aria_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [IdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  logic [BlkW-1:0] q_data_i,
  output logic            valid_o,
  input  logic            stall_i,
  output logic [BlkW-1:0] data_o
);
  typedef enum logic [2:0] {
    Idle, KmRound, KeyGen, KeyRd, Crypt, Fin
  } state_e;

  state_e state_q;
  logic [CfgW-1:0] kw_q [4];
  logic [1:0] klen_q;
  logic dir_q, ready_q;
  logic [BlkW-1:0] w_q [4];
  logic [BlkW-1:0] st_q;
  logic [1:0] km_q;
  logic [4:0] cnt_q;
  logic [4:0] rk_addr;
  logic rk_we;
  logic [BlkW-1:0] rk_wdata, rk_rdata;
  logic [1:0] code;
  logic [4:0] rounds;
  logic [BlkW-1:0] kr, ck, km_next, enc_key, fr_out;

  assign code   = (klen_q == 2'd3) ? 2'd2 : klen_q;
  assign rounds = 5'd12 + {2'b0, code, 1'b0};

  assign kr = (code == 2'd0) ? '0 :
              (code == 2'd1) ? {kw_q[2], 64'h0} : {kw_q[2], kw_q[3]};

  // constant index wraps modulo three
  always_comb begin
    logic [2:0] c;
    c = {1'b0, code} + {1'b0, km_q};
    if (c >= 3'd3) c = c - 3'd3;
    case (c[1:0])
      2'd0: ck = CK0;
      2'd1: ck = CK1;
      default: ck = CK2;
    endcase
  end

  assign km_next = diffuse(subst(w_q[km_q] ^ ck, km_q[0]))
                 ^ ((km_q == 2'd0) ? kr : w_q[km_q - 2'd1]);

  // key index being generated at cnt, honoring direction
  logic [4:0] ki;
  assign ki = dir_q ? (rounds - cnt_q) : cnt_q;
  assign enc_key = w_q[ki[1:0]] ^ rotr(w_q[ki[1:0] + 2'd1], ki[4:2]);
  assign rk_wdata = (dir_q && cnt_q != 5'd0 && cnt_q != rounds) ? diffuse(enc_key) : enc_key;
  assign rk_we = (state_q == KeyGen);

  // one round of the data path
  logic [BlkW-1:0] sb;
  always_comb begin
    sb = subst(st_q ^ rk_rdata, cnt_q[0]);
    fr_out = diffuse(sb);
  end

  always_comb begin
    rk_addr = cnt_q;
    if (state_q == Idle || state_q == KeyGen) rk_addr = 5'd0;
    else if (state_q == KeyRd) rk_addr = 5'd0;
    else if (state_q == Crypt) rk_addr = cnt_q + 5'd1;
  end

  aria_ram #(.Width(BlkW), .Depth(MaxKeys)) u_rk (
    .clk_i, .we_i(rk_we), .waddr_i(cnt_q), .wdata_i(rk_wdata),
    .raddr_i(rk_addr), .rdata_o(rk_rdata)
  );

  assign q_pop_o = (state_q == KeyRd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      ready_q <= 1'b0;
      valid_o <= 1'b0;
      klen_q <= '0;
      dir_q <= 1'b0;
      for (int i = 0; i < 4; i++) kw_q[i] <= '0;
      km_q <= '0;
      cnt_q <= '0;
    end else begin
      if (valid_o && !stall_i) valid_o <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegKey0: kw_q[0] <= cfg_data_i;
          RegKey1: kw_q[1] <= cfg_data_i;
          RegKey2: kw_q[2] <= cfg_data_i;
          RegKey3: kw_q[3] <= cfg_data_i;
          RegKeyLen: klen_q <= cfg_data_i[1:0];
          RegDir: dir_q <= cfg_data_i[0];
          default: ;
        endcase
        if (cfg_idx_i <= RegDir) ready_q <= 1'b0;
      end
      unique case (state_q)
        Idle: begin
          if (q_valid_i && !valid_o) begin
            if (ready_q) state_q <= KeyRd;
            else begin
              w_q[0] <= {kw_q[0], kw_q[1]};
              km_q <= 2'd0;
              state_q <= KmRound;
            end
          end
        end
        KmRound: begin
          w_q[km_q + 2'd1] <= km_next;
          km_q <= km_q + 2'd1;
          if (km_q == 2'd2) begin
            cnt_q <= '0;
            state_q <= KeyGen;
          end
        end
        KeyGen: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == rounds) begin
            ready_q <= 1'b1;
            state_q <= KeyRd;
          end
        end
        KeyRd: begin
          st_q <= q_data_i;
          cnt_q <= '0;
          state_q <= Crypt;
        end
        Crypt: begin
          // cnt counts finished full rounds; rk_rdata holds key cnt
          if (cnt_q + 5'd1 == rounds) begin
            st_q <= subst(st_q ^ rk_rdata, 1'b1);
            state_q <= Fin;
          end else begin
            st_q <= fr_out;
            cnt_q <= cnt_q + 5'd1;
          end
        end
        Fin: begin
          data_o <= st_q ^ rk_rdata;
          valid_o <= 1'b1;
          state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import aria_pkg::*;

  localparam logic [IdxW-1:0] IdxSpareLo = 3'd6;
  localparam logic [IdxW-1:0] IdxSpareHi = 3'd7;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 60;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [IdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic            valid_i = 1'b0;
  logic            stall_o;
  logic [63:0]     block_high_i = '0;
  logic [63:0]     block_low_i = '0;
  logic            valid_o;
  logic            stall_i = 1'b0;
  logic [63:0]     result_high_o;
  logic [63:0]     result_low_o;

  aria_block_cipher dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // cipher state kept by the testbench
  logic [7:0]   sb [4][256];
  int unsigned  mix_tap [16][7] = '{'{3,4,6,8,9,13,14}, '{2,5,7,8,9,12,15},
    '{1,4,6,10,11,12,15}, '{0,5,7,10,11,13,14}, '{0,2,5,8,11,14,15},
    '{1,3,4,9,10,14,15}, '{0,2,7,9,10,12,13}, '{1,3,6,8,11,12,13},
    '{0,1,4,7,10,13,15}, '{0,1,5,6,11,12,14}, '{2,3,5,6,8,13,15},
    '{2,3,4,7,9,12,14}, '{1,2,6,7,9,11,12}, '{0,3,6,7,8,10,13},
    '{0,3,4,5,9,11,14}, '{1,2,4,5,8,10,15}};
  int unsigned  rot_amt [5] = '{19, 31, 67, 97, 109};
  logic [63:0]  key_reg [4];
  logic [1:0]   len_reg;
  logic         dir_reg;
  logic         sched_valid;
  logic [127:0] sched_key [17];

  blk_t pending_blocks [$];
  blk_t expected_ct [$];
  int unsigned issued_n, taken_n, results_n, errors, cycles;
  int unsigned hold_req_n, hold_done_n, hold_left;
  bit no_idle;

  function automatic logic [7:0] fld_mul(logic [7:0] a, logic [7:0] b);
    logic [8:0] x;
    logic [7:0] r;
    x = {1'b0, a};
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= x[7:0];
      x = x << 1;
      if (x[8]) x ^= 9'h11b;
    end
    return r;
  endfunction

  function automatic logic [7:0] fld_pow(logic [7:0] a, int unsigned e);
    logic [7:0] r;
    r = 8'h01;
    while (e != 0) begin
      if (e & 1) r = fld_mul(r, a);
      a = fld_mul(a, a);
      e >>= 1;
    end
    return r;
  endfunction

  task automatic build_sboxes();
    logic [7:0] rows [8];
    logic [7:0] inv, s, p, t;
    rows = '{8'h7A, 8'hBC, 8'hEB, 8'hB9, 8'h34, 8'h81, 8'hBA, 8'hCB};
    for (int x = 0; x < 256; x++) begin
      inv = (x == 0) ? 8'h00 : fld_pow(8'(x), 254);
      s = inv;
      for (int k = 1; k <= 4; k++) s ^= (inv << k) | (inv >> (8 - k));
      s ^= 8'h63;
      p = (x == 0) ? 8'h00 : fld_pow(8'(x), 247);
      for (int i = 0; i < 8; i++) t[i] = ^(rows[i] & p);
      t ^= 8'hE2;
      sb[0][x] = s;
      sb[1][x] = t;
      sb[2][s] = 8'(x);
      sb[3][t] = 8'(x);
    end
  endtask

  function automatic logic [127:0] mix_bytes(logic [127:0] v);
    logic [127:0] o;
    logic [7:0] a;
    for (int i = 0; i < 16; i++) begin
      a = 8'h00;
      for (int j = 0; j < 7; j++) a ^= v[127-8*mix_tap[i][j] -: 8];
      o[127-8*i -: 8] = a;
    end
    return o;
  endfunction

  function automatic logic [127:0] sub_bytes(logic [127:0] v, int unsigned off);
    logic [127:0] o;
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = sb[(i + off) & 3][v[127-8*i -: 8]];
    return o;
  endfunction

  function automatic logic [127:0] round_fn(logic [127:0] v, logic [127:0] k,
                                            int unsigned off);
    return mix_bytes(sub_bytes(v ^ k, off));
  endfunction

  function automatic int unsigned len_code();
    return (len_reg > 2) ? 2 : int'(len_reg);
  endfunction

  task automatic derive_schedule();
    logic [127:0] ck [3];
    logic [127:0] w [4];
    logic [127:0] enc [17];
    logic [127:0] kr, rr;
    int unsigned code, nr;
    code = len_code();
    nr = 12 + 2 * code;
    ck = '{CK0, CK1, CK2};
    kr = '0;
    if (code >= 1) kr[127:64] = key_reg[2];
    if (code == 2) kr[63:0] = key_reg[3];
    w[0] = {key_reg[0], key_reg[1]};
    w[1] = round_fn(w[0], ck[code], 0) ^ kr;
    w[2] = round_fn(w[1], ck[(code + 1) % 3], 2) ^ w[0];
    w[3] = round_fn(w[2], ck[(code + 2) % 3], 0) ^ w[1];
    for (int i = 0; i <= nr; i++) begin
      rr = w[(i + 1) & 3];
      rr = (rr >> rot_amt[i >> 2]) | (rr << (128 - rot_amt[i >> 2]));
      enc[i] = w[i & 3] ^ rr;
    end
    for (int i = 0; i <= nr; i++) begin
      if (!dir_reg) sched_key[i] = enc[i];
      else if (i == 0 || i == nr) sched_key[i] = enc[nr - i];
      else sched_key[i] = mix_bytes(enc[nr - i]);
    end
    sched_valid = 1'b1;
  endtask

  task automatic cipher_block(input blk_t pt, output blk_t ct);
    logic [127:0] b;
    int unsigned nr;
    if (!sched_valid) derive_schedule();
    nr = 12 + 2 * len_code();
    b = pt;
    for (int r = 0; r + 1 < nr; r++) b = round_fn(b, sched_key[r], (r & 1) ? 2 : 0);
    b = sub_bytes(b ^ sched_key[nr - 1], 2) ^ sched_key[nr];
    ct = b;
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // sender
  int unsigned send_gap = 0;
  always @(negedge clk_i) begin
    blk_t nb;
    if (rst_ni && !(valid_i && taken_n == issued_n - 1 && 0) &&
        !(valid_i && taken_n != issued_n)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        valid_i <= 1'b0;
      end else if (pending_blocks.size() > 0) begin
        nb = pending_blocks.pop_front();
        block_high_i <= nb.hi;
        block_low_i <= nb.lo;
        valid_i <= 1'b1;
        issued_n <= issued_n + 1;
        send_gap <= idle_len();
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  // input acceptance and prediction
  always @(posedge clk_i) begin
    blk_t ct;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
    if (rst_ni && valid_i && !stall_o) begin
      cipher_block({block_high_i, block_low_i}, ct);
      expected_ct.push_back(ct);
      taken_n <= taken_n + 1;
    end
  end

  // receiver stall, with an occasional long hold-off
  int unsigned stall_gap = 0;
  always @(negedge clk_i) begin
    if (hold_req_n != hold_done_n) begin
      hold_done_n <= hold_req_n;
      hold_left <= 400;
      stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      stall_i <= 1'b1;
    end else if (stall_gap > 0) begin
      stall_gap <= stall_gap - 1;
      stall_i <= 1'b1;
    end else begin
      stall_i <= 1'b0;
      stall_gap <= idle_len();
    end
  end

  // result check
  always @(posedge clk_i) begin
    blk_t want;
    if (rst_ni && valid_o && !stall_i) begin
      results_n <= results_n + 1;
      if (expected_ct.size() == 0) begin
        $error("result item with no expected value: %h %h", result_high_o, result_low_o);
        errors <= errors + 1;
      end else begin
        want = expected_ct.pop_front();
        if (result_high_o !== want.hi) begin
          $error("result_high expected %h actual %h", want.hi, result_high_o);
          errors <= errors + 1;
        end
        if (result_low_o !== want.lo) begin
          $error("result_low expected %h actual %h", want.lo, result_low_o);
          errors <= errors + 1;
        end
      end
    end
  end

  task automatic reg_write(logic [IdxW-1:0] idx, logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      RegKey0: key_reg[0] = data;
      RegKey1: key_reg[1] = data;
      RegKey2: key_reg[2] = data;
      RegKey3: key_reg[3] = data;
      RegKeyLen: len_reg = data[1:0];
      RegDir: dir_reg = data[0];
      default: ;
    endcase
    if (idx <= RegDir) sched_valid = 1'b0;
  endtask

  task automatic set_cipher(logic [63:0] k0, k1, k2, k3, logic [1:0] len, logic dir);
    logic [CfgW-1:0] lv, dv;
    lv = {rand64() & 64'hffff_ffff_ffff_fffc} | len;
    dv = {rand64() & 64'hffff_ffff_ffff_fffe} | dir;
    reg_write(RegKey0, k0);
    reg_write(RegKey1, k1);
    reg_write(RegKey2, k2);
    reg_write(RegKey3, k3);
    reg_write(RegKeyLen, lv);
    reg_write(RegDir, dv);
    if ($urandom_range(0, 3) == 0) reg_write($urandom_range(0, 1) ? IdxSpareHi : IdxSpareLo,
                                             rand64());
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // checked at the rising edge, after the sender's updates have settled
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_blocks.size() != 0 || expected_ct.size() != 0 || taken_n != issued_n);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [63:0] key_pick();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  initial begin
    int unsigned n;
    logic [1:0] len;
    build_sboxes();
    key_reg = '{default: '0};
    len_reg = '0;
    dir_reg = 1'b0;
    sched_valid = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset key, then extreme blocks
    pending_blocks.push_back('{'0, '0});
    pending_blocks.push_back('{'1, '1});
    wait_idle();
    for (int p = 0; p < 8; p++) begin
      len = 2'(p >> 1);
      if (p < 2) set_cipher('0, '0, '0, '0, len, p[0]);
      else if (p < 4) set_cipher('1, '1, '1, '1, len, p[0]);
      else set_cipher(rand64(), rand64(), rand64(), rand64(), len, p[0]);
      pending_blocks.push_back('{'0, '0});
      pending_blocks.push_back('{'1, '1});
      pending_blocks.push_back('{64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555});
      wait_idle();
    end
    // spare index write must not disturb the schedule
    reg_write(IdxSpareLo, rand64());
    reg_write(IdxSpareHi, rand64());
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pending_blocks.push_back('{rand64(), rand64()});
    wait_idle();

    // receiver holds off while the sender keeps going
    hold_req_n = hold_req_n + 1;
    no_idle = 1'b1;
    for (int i = 0; i < 40; i++) pending_blocks.push_back('{rand64(), rand64()});
    wait_idle();

    for (int p = 0; p < 16; p++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      set_cipher(key_pick(), key_pick(), key_pick(), key_pick(),
                 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      n = $urandom_range(60, 90);
      for (int i = 0; i < n; i++) pending_blocks.push_back('{rand64(), rand64()});
      wait_idle();
    end

    $display("covered all key lengths and both directions with %0d blocks in, %0d out",
             taken_n, results_n);
    $display("including extreme keys and blocks, spare index writes and a long output hold");
    if (errors == 0 && expected_ct.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
